### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every cycle outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, also checked while reset is asserted.
`define ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/core/sler_pkg.sv
// ---------------------------------------------------------------------------
// sler_pkg
// Constants, widths and codes for the STX/length/ETX frame receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package sler_pkg;

  // Frame limits
  localparam int MAX_PACKET  = 4096;
  localparam int STORE_DEPTH = MAX_PACKET + 64;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  // Field widths
  localparam int POS_W  = 13;                    // positions, lengths, host buffer size
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 17;                    // 16-bit length plus one
  localparam int BL_W   = $clog2(MAX_PACKET);    // bytes left in a frame

  localparam logic [POS_W-1:0] HOST_LEN_RST = POS_W'(4160);

  // Framing bytes
  localparam logic [BYTE_W-1:0] STX_BYTE     = 8'h02;
  localparam logic [BYTE_W-1:0] ETX_BYTE     = 8'h03;
  localparam logic [BYTE_W-1:0] STATUS_OK    = 8'hff;
  localparam logic [BYTE_W-1:0] STATUS_TRUNC = 8'hfe;

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result kinds
  localparam logic RES_FRAME = 1'b0;
  localparam logic RES_READ  = 1'b1;

endpackage

`default_nettype wire

### rtl/core/sler_ifs.sv
// ---------------------------------------------------------------------------
// sler_ifs
// Valid/ready channel interfaces for input, result and configuration words.
// ---------------------------------------------------------------------------
`default_nettype none

interface sler_in_if import sler_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [BYTE_W-1:0] rx_byte;
  logic              chunk_last;
  logic              restart;
  logic [POS_W-1:0]  read_index;

  modport source (output valid, operation, rx_byte, chunk_last, restart, read_index,
                  input ready);
  modport sink   (input valid, operation, rx_byte, chunk_last, restart, read_index,
                  output ready);
endinterface

interface sler_out_if import sler_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic              frame_status;
  logic [POS_W-1:0]  frame_length;
  logic [BYTE_W-1:0] read_byte;

  modport source (output valid, result_kind, frame_status, frame_length, read_byte,
                  input ready);
  modport sink   (input valid, result_kind, frame_status, frame_length, read_byte,
                  output ready);
endinterface

interface sler_cfg_if import sler_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] host_buffer_len;

  modport source (output valid, host_buffer_len, input ready);
  modport sink   (input valid, host_buffer_len, output ready);
endinterface

`default_nettype wire

### rtl/core/sler_ram.sv
// ---------------------------------------------------------------------------
// sler_ram
// Simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module sler_ram #(
  parameter int DEPTH = 4160,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered, holds when idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/stx_length_etx_frame_receiver.sv
// ---------------------------------------------------------------------------
// stx_length_etx_frame_receiver
// Hunts STX, takes a 16-bit length, stores the frame body in a RAM, checks
// ETX and reports completion; read words return stored frame bytes.
// ---------------------------------------------------------------------------
// Channel  Dir  Payload                                              Flow
// in_ch    in   operation, rx_byte, chunk_last, restart, read_index  valid/ready
// out_ch   out  result_kind, frame_status, frame_length, read_byte   valid/ready
// cfg_ch   in   host_buffer_len                                      valid/ready
//
// One input word per cycle while in_ch.ready is high; a result passes through
// the read stage (registered RAM read) and then the output register.
// Synchronous active-low reset; the frame RAM is not cleared, slot 0
// (status) lives in a flop. Output stalls back up to in_ch.ready through the
// read stage; pushes that cause no result still wait while that stage is full.
// ---------------------------------------------------------------------------
`default_nettype none

module stx_length_etx_frame_receiver
  import sler_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  sler_in_if.sink     in_ch,
  sler_out_if.source  out_ch,
  sler_cfg_if.sink    cfg_ch
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_DATA
  } phase_t;

  // control state
  phase_t            phase_r,  phase_nxt;
  logic              disc_r,   disc_nxt;
  logic              fvalid_r, fvalid_nxt;
  logic              trunc_r,  trunc_nxt;
  logic [POS_W-1:0]  wp_r,     wp_nxt;
  logic [BL_W-1:0]   bl_r,     bl_nxt;
  logic [BYTE_W-1:0] len_hi_r, len_hi_nxt;
  logic [BYTE_W-1:0] prev_r,   prev_nxt;
  logic [POS_W-1:0]  hbl_r;

  // read stage and output register
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_kind_r, s1_trunc_r, s1_hit_r, s1_slot0_r;
  logic [POS_W-1:0]  s1_len_r;
  logic              out_valid_r;
  logic              out_kind_r, out_status_r;
  logic [POS_W-1:0]  out_len_r;
  logic [BYTE_W-1:0] out_byte_r;

  // datapath nets
  logic              in_acc, push_acc, read_acc, s1_adv;
  phase_t            phase_v;
  logic              disc_v;
  logic [POS_W-1:0]  wp_inc;
  logic [LEN_W-1:0]  len_sum;
  logic              cmp_valid, cmp_trunc;
  logic              rd_hit, rd_slot0;
  logic              st_wr_en;
  logic [POS_W-1:0]  st_wr_addr;
  logic [BYTE_W-1:0] st_rd_data;
  logic [BYTE_W-1:0] s1_byte;

  // handshakes
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign push_acc    = in_acc && (in_ch.operation == OP_PUSH);
  assign read_acc    = in_acc && (in_ch.operation == OP_READ);
  assign cfg_ch.ready = 1'b1;

  assign wp_inc  = wp_r + POS_W'(1);
  assign len_sum = {1'b0, len_hi_r, in_ch.rx_byte} + LEN_W'(1);

  // read window: completed frame, below both its length and the host buffer
  assign rd_hit   = fvalid_r && (in_ch.read_index < wp_r) && (in_ch.read_index < hbl_r);
  assign rd_slot0 = (in_ch.read_index == '0);

  // receive sequencer
  always_comb begin
    phase_nxt  = phase_r;
    disc_nxt   = disc_r;
    fvalid_nxt = fvalid_r;
    trunc_nxt  = trunc_r;
    wp_nxt     = wp_r;
    bl_nxt     = bl_r;
    len_hi_nxt = len_hi_r;
    prev_nxt   = prev_r;
    st_wr_en   = 1'b0;
    st_wr_addr = wp_r;
    cmp_valid  = 1'b0;
    cmp_trunc  = 1'b0;
    phase_v    = in_ch.restart ? PH_HUNT : phase_r;
    disc_v     = in_ch.restart ? 1'b0 : disc_r;
    if (push_acc) begin
      phase_nxt = phase_v;
      if (disc_v) begin
        // drop bytes up to and including the chunk end
        disc_nxt = !in_ch.chunk_last;
      end else begin
        disc_nxt = 1'b0;
        unique case (phase_v)
          PH_HUNT: begin
            if (in_ch.rx_byte == STX_BYTE) begin
              fvalid_nxt = 1'b0;
              st_wr_en   = 1'b1;
              st_wr_addr = POS_W'(1);
              wp_nxt     = POS_W'(2);
              prev_nxt   = in_ch.rx_byte;
              phase_nxt  = PH_LEN_HI;
            end
          end
          PH_LEN_HI: begin
            len_hi_nxt = in_ch.rx_byte;
            st_wr_en   = 1'b1;
            wp_nxt     = wp_inc;
            prev_nxt   = in_ch.rx_byte;
            phase_nxt  = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            if (len_sum >= LEN_W'(MAX_PACKET)) begin
              phase_nxt = PH_HUNT;
            end else begin
              st_wr_en  = 1'b1;
              wp_nxt    = wp_inc;
              prev_nxt  = in_ch.rx_byte;
              bl_nxt    = len_sum[BL_W-1:0];
              phase_nxt = PH_DATA;
            end
          end
          PH_DATA: begin
            st_wr_en = 1'b1;
            wp_nxt   = wp_inc;
            prev_nxt = in_ch.rx_byte;
            bl_nxt   = bl_r - BL_W'(1);
            if (bl_r == BL_W'(1)) begin
              phase_nxt = PH_HUNT;
              // byte before the last must be ETX
              if (prev_r == ETX_BYTE) begin
                cmp_valid  = 1'b1;
                cmp_trunc  = (hbl_r < wp_inc);
                trunc_nxt  = cmp_trunc;
                fvalid_nxt = 1'b1;
                disc_nxt   = !in_ch.chunk_last;
              end
            end
          end
          default: phase_nxt = PH_HUNT;
        endcase
      end
    end
  end

  always_comb begin
    if (in_acc && ((in_ch.operation == OP_READ) || cmp_valid)) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  // frame store
  sler_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (BYTE_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr[STORE_AW-1:0]),
    .wr_data (in_ch.rx_byte),
    .rd_en   (read_acc),
    .rd_addr (in_ch.read_index[STORE_AW-1:0]),
    .rd_data (st_rd_data)
  );

  // read byte: status flop for slot 0, RAM otherwise, zero outside the window
  always_comb begin
    s1_byte = '0;
    if (s1_kind_r == RES_READ && s1_hit_r) begin
      if (s1_slot0_r) begin
        s1_byte = s1_trunc_r ? STATUS_TRUNC : STATUS_OK;
      end else begin
        s1_byte = st_rd_data;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      disc_r      <= 1'b0;
      fvalid_r    <= 1'b0;
      wp_r        <= POS_W'(1);
      bl_r        <= '0;
      hbl_r       <= HOST_LEN_RST;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      disc_r     <= disc_nxt;
      fvalid_r   <= fvalid_nxt;
      wp_r       <= wp_nxt;
      bl_r       <= bl_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        hbl_r <= cfg_ch.host_buffer_len;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    trunc_r  <= trunc_nxt;
    len_hi_r <= len_hi_nxt;
    prev_r   <= prev_nxt;
    if (in_acc) begin
      if (in_ch.operation == OP_READ) begin
        s1_kind_r  <= RES_READ;
        s1_trunc_r <= trunc_r;
        s1_len_r   <= '0;
        s1_hit_r   <= rd_hit;
        s1_slot0_r <= rd_slot0;
      end else begin
        s1_kind_r  <= RES_FRAME;
        s1_trunc_r <= cmp_trunc;
        s1_len_r   <= wp_inc;
        s1_hit_r   <= 1'b0;
        s1_slot0_r <= 1'b0;
      end
    end
    if (s1_adv) begin
      out_kind_r   <= s1_kind_r;
      out_status_r <= (s1_kind_r == RES_FRAME) ? s1_trunc_r : 1'b0;
      out_len_r    <= s1_len_r;
      out_byte_r   <= s1_byte;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = out_kind_r;
  assign out_ch.frame_status = out_status_r;
  assign out_ch.frame_length = out_len_r;
  assign out_ch.read_byte    = out_byte_r;

endmodule

`default_nettype wire

### rtl/core/sler_chk.sv
// ---------------------------------------------------------------------------
// sler_chk
// Port-level checker for the frame receiver, attached by bind.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sler_chk
  import sler_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              result_kind,
  input wire logic              frame_status,
  input wire logic [POS_W-1:0]  frame_length,
  input wire logic [BYTE_W-1:0] read_byte
);

  // a stalled result word stays offered
  `ASSERT_IMPLY(a_out_hold, clk, rst_n, out_valid && !out_ready, ##1 out_valid)

  // read words carry no frame status or length
  `ASSERT_IMPLY(a_read_clean, clk, rst_n, out_valid && result_kind == RES_READ, frame_status == 1'b0 && frame_length == '0)

  // completion words: no data byte, at least STX, length and one body byte
  `ASSERT_IMPLY(a_frame_shape, clk, rst_n, out_valid && result_kind == RES_FRAME, read_byte == '0 && frame_length >= POS_W'(5))

  // reset empties the result register
  `ASSERT_NEXT(a_reset_idle, clk, !rst_n, !out_valid)

endmodule

bind stx_length_etx_frame_receiver sler_chk u_sler_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .result_kind  (out_ch.result_kind),
  .frame_status (out_ch.frame_status),
  .frame_length (out_ch.frame_length),
  .read_byte    (out_ch.read_byte)
);

`default_nettype wire
